FILE: rtl/core/rrfp_pkg.sv
// Shared types, codes and constants of the reader response frame parser.
`default_nettype none

package rrfp_pkg;

    // Largest declared payload that is accepted
    localparam int MAX_PAYLOAD = 512;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int PLEN_W      = 10;
    localparam int PIDX_W      = 9;
    localparam int TICK_W      = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;

    // Input item codes (func)
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FINISH  = 1'b1;

    // Frame outcomes
    localparam logic [1:0] OUT_SUCCESS = 2'd0;
    localparam logic [1:0] OUT_NAK     = 2'd1;
    localparam logic [1:0] OUT_TOO_BIG = 2'd2;
    localparam logic [1:0] OUT_TIMEOUT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TPU     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFWAIT = 3'd4;

    // Configuration reset values
    localparam logic [7:0]            RST_SYNC    = 8'h03;
    localparam logic [7:0]            RST_ACK     = 8'h06;
    localparam logic [7:0]            RST_NAK     = 8'h15;
    localparam logic [CFG_DATA_W-1:0] RST_TPU     = 14'd10000;
    localparam logic [CFG_DATA_W-1:0] RST_DEFWAIT = 14'd500;

    // Bytes that restart the timeout while hunting for sync
    localparam logic [7:0] IDLE_BYTE_A = 8'h50;
    localparam logic [7:0] IDLE_BYTE_B = 8'h60;
    localparam logic [7:0] HIGH_BYTE   = 8'h80;

    typedef struct packed {
        logic [7:0]            sync_value;
        logic [7:0]            ack_value;
        logic [7:0]            nak_value;
        logic [CFG_DATA_W-1:0] ticks_per_unit;
        logic [CFG_DATA_W-1:0] default_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic [7:0] max_time_count;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        payload_byte;
        logic [PIDX_W-1:0] payload_index;
        logic [7:0]        message_type;
        logic [PLEN_W-1:0] payload_length;
        logic [7:0]        slot_id;
        logic [7:0]        sequence_number;
        logic [7:0]        response_status;
        logic [7:0]        error_byte;
        logic [7:0]        protocol_byte;
        logic [1:0]        outcome;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rrfp_cfg.sv
// Configuration register file of the frame parser.
`default_nettype none

module rrfp_cfg
    import rrfp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    // Write one register per enabled edge; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value         <= RST_SYNC;
            cfg_reg.ack_value          <= RST_ACK;
            cfg_reg.nak_value          <= RST_NAK;
            cfg_reg.ticks_per_unit     <= RST_TPU;
            cfg_reg.default_wait_ticks <= RST_DEFWAIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC:    cfg_reg.sync_value         <= cfg_data[7:0];
                CFG_ACK:     cfg_reg.ack_value          <= cfg_data[7:0];
                CFG_NAK:     cfg_reg.nak_value          <= cfg_data[7:0];
                CFG_TPU:     cfg_reg.ticks_per_unit     <= cfg_data;
                CFG_DEFWAIT: cfg_reg.default_wait_ticks <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rrfp_in_stage.sv
// Input register of the frame parser.
`default_nettype none

module rrfp_in_stage
    import rrfp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    // Accept when empty or when the held item moves on this cycle
    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold the item payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rrfp_core.sv
// Frame parsing state, timeout counter and result register.
`default_nettype none

module rrfp_core
    import rrfp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    input  wire item_t item,
    output logic       take,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_SYNC, PH_ACK, PH_TYPE, PH_LEN, PH_SLOT,
        PH_SEQ, PH_STAT, PH_ERR, PH_PROTO, PH_DATA, PH_CHECK
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         chk_reg, chk_next;
    logic [1:0]         lbc_reg, lbc_next;
    logic [PLEN_W-1:0]  len_reg, len_next;
    logic               big_reg, big_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         slot_reg, slot_next;
    logic [7:0]         seq_reg, seq_next;
    logic [7:0]         stat_reg, stat_next;
    logic [7:0]         err_reg, err_next;
    logic [7:0]         proto_reg, proto_next;
    logic               wait_reg, wait_next;
    logic [TICK_W-1:0]  tcnt_reg, tcnt_next;
    logic [TICK_W-1:0]  tlim_reg, tlim_next;
    logic               out_valid_reg;
    result_t            result_reg;

    logic               fire;
    logic               emit;
    logic               emit_kind;
    logic [PIDX_W-1:0]  emit_index;
    logic [1:0]         emit_outcome;
    logic [7:0]         b;
    logic               too_big;
    logic [PLEN_W-1:0]  len_sat;

    // Move the held item when the result register is free or drains
    assign take = !out_valid_reg || out_ready;
    assign fire = item_valid && take;
    assign b    = item.rx_byte;

    // Next state for one item
    always_comb
    begin
        phase_next   = phase_reg;
        chk_next     = chk_reg;
        lbc_next     = lbc_reg;
        len_next     = len_reg;
        big_next     = big_reg;
        cnt_next     = cnt_reg;
        type_next    = type_reg;
        slot_next    = slot_reg;
        seq_next     = seq_reg;
        stat_next    = stat_reg;
        err_next     = err_reg;
        proto_next   = proto_reg;
        wait_next    = wait_reg;
        tcnt_next    = tcnt_reg;
        tlim_next    = tlim_reg;
        emit         = 1'b0;
        emit_kind    = KIND_FINISH;
        emit_index   = '0;
        emit_outcome = OUT_SUCCESS;
        too_big      = 1'b0;

        if (fire)
        begin
            if (item.func == FUNC_START)
            begin
                // Arm a new exchange
                if (item.max_time_count != 8'd0)
                begin
                    tlim_next = TICK_W'(item.max_time_count) * TICK_W'(cfg.ticks_per_unit);
                end
                else
                begin
                    tlim_next = TICK_W'(cfg.default_wait_ticks);
                end
                tcnt_next  = '0;
                chk_next   = '0;
                lbc_next   = '0;
                len_next   = '0;
                big_next   = 1'b0;
                cnt_next   = '0;
                wait_next  = 1'b0;
                type_next  = '0;
                slot_next  = '0;
                seq_next   = '0;
                stat_next  = '0;
                err_next   = '0;
                proto_next = '0;
                phase_next = PH_SYNC;
            end
            else if (phase_reg != PH_IDLE && item.func == FUNC_TICK)
            begin
                // Count one tick and end the frame at the limit
                if (tcnt_reg < tlim_reg)
                begin
                    tcnt_next = tcnt_reg + 1'b1;
                end
                if (tcnt_next >= tlim_reg)
                begin
                    emit         = 1'b1;
                    emit_outcome = OUT_TIMEOUT;
                    phase_next   = PH_IDLE;
                end
            end
            else if (phase_reg != PH_IDLE && item.func == FUNC_BYTE)
            begin
                unique case (phase_reg)
                    PH_SYNC:
                    begin
                        if (b == cfg.sync_value)
                        begin
                            chk_next   = cfg.sync_value;
                            phase_next = PH_ACK;
                        end
                        else if (b == IDLE_BYTE_A || b == IDLE_BYTE_B || b >= HIGH_BYTE)
                        begin
                            tcnt_next = '0;
                        end
                    end
                    PH_ACK:
                    begin
                        if (b == cfg.ack_value)
                        begin
                            chk_next   = chk_reg ^ b;
                            phase_next = PH_TYPE;
                        end
                        else if (b == cfg.nak_value)
                        begin
                            emit         = 1'b1;
                            emit_outcome = OUT_NAK;
                            phase_next   = PH_IDLE;
                        end
                    end
                    PH_TYPE:
                    begin
                        chk_next   = chk_reg ^ b;
                        type_next  = b;
                        len_next   = '0;
                        big_next   = 1'b0;
                        lbc_next   = '0;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        // Little-endian length; anything above bit 9 marks it too large
                        chk_next = chk_reg ^ b;
                        unique case (lbc_reg)
                            2'd0:    len_next[7:0] = len_reg[7:0] | b;
                            2'd1:
                            begin
                                len_next[9:8] = len_reg[9:8] | b[1:0];
                                big_next      = big_reg | (|b[7:2]);
                            end
                            default: big_next = big_reg | (|b);
                        endcase
                        lbc_next = lbc_reg + 1'b1;
                        if (lbc_reg == 2'd3)
                        begin
                            too_big = big_next || (len_next > PLEN_W'(MAX_PAYLOAD));
                            if (too_big)
                            begin
                                emit         = 1'b1;
                                emit_outcome = OUT_TOO_BIG;
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_SLOT;
                            end
                        end
                    end
                    PH_SLOT:
                    begin
                        chk_next   = chk_reg ^ b;
                        slot_next  = b;
                        phase_next = PH_SEQ;
                    end
                    PH_SEQ:
                    begin
                        chk_next   = chk_reg ^ b;
                        seq_next   = b;
                        phase_next = PH_STAT;
                    end
                    PH_STAT:
                    begin
                        wait_next  = wait_reg | (b >= HIGH_BYTE);
                        chk_next   = chk_reg ^ b;
                        stat_next  = b;
                        phase_next = PH_ERR;
                    end
                    PH_ERR:
                    begin
                        chk_next   = chk_reg ^ b;
                        err_next   = b;
                        phase_next = PH_PROTO;
                    end
                    PH_PROTO:
                    begin
                        chk_next   = chk_reg ^ b;
                        proto_next = b;
                        cnt_next   = '0;
                        phase_next = (len_reg == '0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        // Deliver one payload byte
                        chk_next   = chk_reg ^ b;
                        emit       = 1'b1;
                        emit_kind  = KIND_PAYLOAD;
                        emit_index = cnt_reg[PIDX_W-1:0];
                        cnt_next   = cnt_reg + 1'b1;
                        if (CNT_W'(cnt_next) >= CNT_W'(len_reg))
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        // Drop a bad check byte; resync on a wait request
                        if (b == chk_reg)
                        begin
                            if (wait_reg)
                            begin
                                chk_next   = '0;
                                lbc_next   = '0;
                                len_next   = '0;
                                big_next   = 1'b0;
                                cnt_next   = '0;
                                wait_next  = 1'b0;
                                slot_next  = '0;
                                stat_next  = '0;
                                err_next   = '0;
                                phase_next = PH_SYNC;
                            end
                            else
                            begin
                                emit         = 1'b1;
                                emit_outcome = OUT_SUCCESS;
                                phase_next   = PH_IDLE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Length as reported, saturated while it is known to be too large
    assign len_sat = (big_next || len_next > PLEN_W'(MAX_PAYLOAD)) ?
                     PLEN_W'(MAX_PAYLOAD) : len_next;

    // Hold parser state and load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            chk_reg       <= '0;
            lbc_reg       <= '0;
            len_reg       <= '0;
            big_reg       <= 1'b0;
            cnt_reg       <= '0;
            type_reg      <= '0;
            slot_reg      <= '0;
            seq_reg       <= '0;
            stat_reg      <= '0;
            err_reg       <= '0;
            proto_reg     <= '0;
            wait_reg      <= 1'b0;
            tcnt_reg      <= '0;
            tlim_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            chk_reg   <= chk_next;
            lbc_reg   <= lbc_next;
            len_reg   <= len_next;
            big_reg   <= big_next;
            cnt_reg   <= cnt_next;
            type_reg  <= type_next;
            slot_reg  <= slot_next;
            seq_reg   <= seq_next;
            stat_reg  <= stat_next;
            err_reg   <= err_next;
            proto_reg <= proto_next;
            wait_reg  <= wait_next;
            tcnt_reg  <= tcnt_next;
            tlim_reg  <= tlim_next;
            if (take)
            begin
                out_valid_reg <= emit;
            end
            if (emit)
            begin
                result_reg.kind            <= emit_kind;
                result_reg.payload_byte    <= (emit_kind == KIND_PAYLOAD) ? b : 8'd0;
                result_reg.payload_index   <= emit_index;
                result_reg.message_type    <= type_next;
                result_reg.payload_length  <= len_sat;
                result_reg.slot_id         <= slot_next;
                result_reg.sequence_number <= seq_next;
                result_reg.response_status <= stat_next;
                result_reg.error_byte      <= err_next;
                result_reg.protocol_byte   <= proto_next;
                result_reg.outcome         <= emit_outcome;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/reader_response_frame_parser.sv
// Top level of the reader response frame parser.
`default_nettype none

// Takes one item per clock while no result waits on m_tready: start, received
// byte or timer tick. Every item passes an input register and the parser's state
// update, and any result is loaded into the output register as the item leaves
// the input register. Throughput is one item per cycle unless m_tready stalls; while a result waits
// on m_tready, one more item is held in the input register. Payload bytes come
// out as kind 0 results, and each frame that ends gives one kind 1 outcome result.
module reader_response_frame_parser
    import rrfp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // rx_byte, max_time_count
    input  wire logic [1:0]            s_tuser,   // func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [79:0]                m_tdata,   // payload_byte, payload_index,
                                                  // message_type, payload_length,
                                                  // slot_id, sequence_number,
                                                  // response_status, error_byte,
                                                  // protocol_byte, outcome, zero pad
    output logic [0:0]                 m_tuser,   // kind
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t result;

    assign in_item.func           = s_tuser;
    assign in_item.rx_byte        = s_tdata[7:0];
    assign in_item.max_time_count = s_tdata[15:8];

    rrfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rrfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rrfp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    // Pack the result item
    assign m_tuser = result.kind;
    assign m_tdata = {3'b000,
                      result.outcome,
                      result.protocol_byte,
                      result.error_byte,
                      result.response_status,
                      result.sequence_number,
                      result.slot_id,
                      result.payload_length,
                      result.message_type,
                      result.payload_index,
                      result.payload_byte};

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A start item produces no result
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && take && item.func == FUNC_START) |=> !m_tvalid)
        else $error("result after start item");

    // A payload byte sits inside the declared length
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result.kind == KIND_PAYLOAD) |->
        (PLEN_W'(result.payload_index) < result.payload_length))
        else $error("payload index beyond declared length");

endmodule

`default_nettype wire

FILE: tb/reader_response_frame_parser_tb.sv
// Self-checking testbench for the reader response frame parser.
`timescale 1ns / 1ps

module reader_response_frame_parser_tb;
    import rrfp_pkg::*;

    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HUNT,
        ST_ACK,
        ST_TYPE,
        ST_LEN,
        ST_SLOT,
        ST_SEQ,
        ST_STATUS,
        ST_ERROR,
        ST_PROTO,
        ST_PAYLOAD,
        ST_CHECK
    } frame_phase_e;

    // Tracks the parser state and holds the results still due from the block
    class frame_scoreboard;
        logic [7:0]            sync_byte;
        logic [7:0]            ack_byte;
        logic [7:0]            nak_byte;
        logic [CFG_DATA_W-1:0] ticks_per_unit;
        logic [CFG_DATA_W-1:0] default_wait;
        frame_phase_e          phase;
        logic [7:0]            xor_sum;
        logic [1:0]            len_cnt;
        logic [31:0]           decl_len;
        logic [9:0]            pay_cnt;
        logic [7:0]            msg_type;
        logic [7:0]            slot_no;
        logic [7:0]            seq_no;
        logic [7:0]            status;
        logic [7:0]            err_code;
        logic [7:0]            proto;
        bit                    wait_req;
        logic [TICK_W-1:0]     ticks;
        logic [TICK_W-1:0]     tick_limit;
        result_t               results_due[$];
        int                    errors;

        function new();
            sync_byte      = RST_SYNC;
            ack_byte       = RST_ACK;
            nak_byte       = RST_NAK;
            ticks_per_unit = RST_TPU;
            default_wait   = RST_DEFWAIT;
            phase          = ST_IDLE;
            clear_frame();
            clear_headers();
            ticks          = '0;
            tick_limit     = '0;
            errors         = 0;
        endfunction

        function void clear_frame();
            xor_sum  = '0;
            len_cnt  = '0;
            decl_len = '0;
            pay_cnt  = '0;
            wait_req = 1'b0;
        endfunction

        function void clear_headers();
            msg_type = '0;
            slot_no  = '0;
            seq_no   = '0;
            status   = '0;
            err_code = '0;
            proto    = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SYNC:    sync_byte      = value[7:0];
                CFG_ACK:     ack_byte       = value[7:0];
                CFG_NAK:     nak_byte       = value[7:0];
                CFG_TPU:     ticks_per_unit = value;
                CFG_DEFWAIT: default_wait   = value;
                default:     ;
            endcase
        endfunction

        // Queue one result with the header fields captured so far
        function void push_result(logic kind, logic [7:0] data_byte,
                                  logic [PIDX_W-1:0] idx, logic [1:0] outcome);
            result_t r;
            r.kind            = kind;
            r.payload_byte    = data_byte;
            r.payload_index   = idx;
            r.message_type    = msg_type;
            r.payload_length  = (decl_len > MAX_PAYLOAD) ? PLEN_W'(MAX_PAYLOAD)
                                                         : decl_len[PLEN_W-1:0];
            r.slot_id         = slot_no;
            r.sequence_number = seq_no;
            r.response_status = status;
            r.error_byte      = err_code;
            r.protocol_byte   = proto;
            r.outcome         = outcome;
            results_due.push_back(r);
        endfunction

        function void end_frame(logic [1:0] outcome);
            push_result(KIND_FINISH, 8'h00, '0, outcome);
            phase = ST_IDLE;
        endfunction

        // Walk one received byte through the frame
        function void take_byte(logic [7:0] b);
            case (phase)
                ST_HUNT:
                begin
                    if (b == sync_byte)
                    begin
                        xor_sum = sync_byte;
                        phase   = ST_ACK;
                    end
                    else if (b == IDLE_BYTE_A || b == IDLE_BYTE_B || b >= HIGH_BYTE)
                        ticks = '0;
                end
                ST_ACK:
                begin
                    if (b == ack_byte)
                    begin
                        xor_sum ^= b;
                        phase    = ST_TYPE;
                    end
                    else if (b == nak_byte)
                        end_frame(OUT_NAK);
                end
                ST_TYPE:
                begin
                    xor_sum ^= b;
                    msg_type = b;
                    decl_len = '0;
                    len_cnt  = '0;
                    phase    = ST_LEN;
                end
                ST_LEN:
                begin
                    xor_sum ^= b;
                    decl_len |= 32'(b) << (8 * int'(len_cnt));
                    len_cnt  = len_cnt + 2'd1;
                    if (len_cnt == 2'd0)
                    begin
                        if (decl_len > MAX_PAYLOAD)
                            end_frame(OUT_TOO_BIG);
                        else
                            phase = ST_SLOT;
                    end
                end
                ST_SLOT:
                begin
                    xor_sum ^= b;
                    slot_no  = b;
                    phase    = ST_SEQ;
                end
                ST_SEQ:
                begin
                    xor_sum ^= b;
                    seq_no   = b;
                    phase    = ST_STATUS;
                end
                ST_STATUS:
                begin
                    if (b >= HIGH_BYTE)
                        wait_req = 1'b1;
                    xor_sum ^= b;
                    status   = b;
                    phase    = ST_ERROR;
                end
                ST_ERROR:
                begin
                    xor_sum ^= b;
                    err_code = b;
                    phase    = ST_PROTO;
                end
                ST_PROTO:
                begin
                    xor_sum ^= b;
                    proto    = b;
                    pay_cnt  = '0;
                    phase    = (decl_len == 0) ? ST_CHECK : ST_PAYLOAD;
                end
                ST_PAYLOAD:
                begin
                    xor_sum ^= b;
                    push_result(KIND_PAYLOAD, b, pay_cnt[PIDX_W-1:0], OUT_SUCCESS);
                    pay_cnt = pay_cnt + 10'd1;
                    if (pay_cnt >= decl_len)
                        phase = ST_CHECK;
                end
                ST_CHECK:
                begin
                    // A wrong check byte is dropped; a wait request resyncs silently
                    if (b == xor_sum)
                    begin
                        if (wait_req)
                        begin
                            clear_frame();
                            slot_no  = '0;
                            status   = '0;
                            err_code = '0;
                            phase    = ST_HUNT;
                        end
                        else
                            end_frame(OUT_SUCCESS);
                    end
                end
                default: ;
            endcase
        endfunction

        // Advance the parser by one accepted item
        function void advance_parser(logic [1:0] func, logic [7:0] b, logic [7:0] units);
            int unsigned span;
            if (func == FUNC_START)
            begin
                span = (units != 0) ? 32'(units) * 32'(ticks_per_unit) : 32'(default_wait);
                tick_limit = span[TICK_W-1:0];
                ticks      = '0;
                clear_frame();
                clear_headers();
                phase = ST_HUNT;
                return;
            end
            if (phase == ST_IDLE)
                return;
            if (func == FUNC_BYTE)
                take_byte(b);
            else if (func == FUNC_TICK)
            begin
                if (ticks < tick_limit)
                    ticks = ticks + 1'b1;
                if (ticks >= tick_limit)
                    end_frame(OUT_TIMEOUT);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Compare one delivered result with the oldest one due
        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = results_due.pop_front();
            compare_field("kind",            want.kind,            got.kind);
            compare_field("payload_byte",    want.payload_byte,    got.payload_byte);
            compare_field("payload_index",   want.payload_index,   got.payload_index);
            compare_field("message_type",    want.message_type,    got.message_type);
            compare_field("payload_length",  want.payload_length,  got.payload_length);
            compare_field("slot_id",         want.slot_id,         got.slot_id);
            compare_field("sequence_number", want.sequence_number, got.sequence_number);
            compare_field("response_status", want.response_status, got.response_status);
            compare_field("error_byte",      want.error_byte,      got.error_byte);
            compare_field("protocol_byte",   want.protocol_byte,   got.protocol_byte);
            compare_field("outcome",         want.outcome,         got.outcome);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // rx_byte, max_time_count
    logic [1:0]            s_tuser   = '0;   // func
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [79:0]           m_tdata;          // payload_byte, payload_index, message_type,
                                             // payload_length, slot_id, sequence_number,
                                             // response_status, error_byte, protocol_byte,
                                             // outcome, zero pad
    logic [0:0]            m_tuser;          // kind
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    frame_scoreboard sb;
    int  items_sent   = 0;
    int  idle_cycles  = 0;
    bit  steady       = 1'b0;
    bit  rx_steady    = 1'b0;
    int  rx_hold      = 0;
    int  rx_pick;

    reader_response_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic result_t unpack_result(logic [79:0] d, logic k);
        result_t r;
        r.kind            = k;
        r.payload_byte    = d[7:0];
        r.payload_index   = d[16:8];
        r.message_type    = d[24:17];
        r.payload_length  = d[34:25];
        r.slot_id         = d[42:35];
        r.sequence_number = d[50:43];
        r.response_status = d[58:51];
        r.error_byte      = d[66:59];
        r.protocol_byte   = d[74:67];
        r.outcome         = d[76:75];
        return r;
    endfunction

    // Check every delivered result
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(unpack_result(m_tdata, m_tuser[0]));

    // End the run when nothing moves for too long
    always @(posedge clk)
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end

    // Stall the result side: mostly short holds, a few long, some steady stretches
    always @(negedge clk)
        if (rx_hold > 0)
        begin
            m_tready = 1'b0;
            rx_hold--;
        end
        else
        begin
            m_tready = 1'b1;
            if ($urandom_range(0, 99) == 0)
                rx_steady = ~rx_steady;
            rx_pick = $urandom_range(0, 99);
            if (!rx_steady)
            begin
                if (rx_pick < 20)
                    rx_hold = $urandom_range(1, 2);
                else if (rx_pick < 24)
                    rx_hold = $urandom_range(3, 10);
                else if (rx_pick < 25)
                    rx_hold = $urandom_range(20, 60);
            end
        end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one item and wait for it to be accepted; ends on a falling edge
    task automatic send_item(input logic [1:0] func, input logic [7:0] data_byte,
                             input logic [7:0] units);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {units, data_byte};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (func == FUNC_START || sb.phase != ST_IDLE)
            items_sent++;
        sb.advance_parser(func, data_byte, units);
        @(negedge clk);
    endtask

    // Hold the sender until every due result has come, then let the block settle
    task automatic drain_results();
        s_tvalid = 1'b0;
        @(posedge clk);
        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [7:0] sync_v, input logic [7:0] ack_v,
                             input logic [7:0] nak_v, input logic [CFG_DATA_W-1:0] tpu,
                             input logic [CFG_DATA_W-1:0] def_wait);
        drain_results();
        write_reg(CFG_SYNC, CFG_DATA_W'(sync_v));
        write_reg(CFG_ACK, CFG_DATA_W'(ack_v));
        write_reg(CFG_NAK, CFG_DATA_W'(nak_v));
        write_reg(CFG_TPU, tpu);
        write_reg(CFG_DEFWAIT, def_wait);
    endtask

    // Declared payload length for the next frame: mostly short, a few full or oversized
    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 4);
        if (r < 80)
            return $urandom_range(5, 24);
        if (r < 89)
            return $urandom_range(25, 100);
        if (r < 91)
            return $urandom_range(500, MAX_PAYLOAD);
        if (r < 95)
            return $urandom_range(MAX_PAYLOAD + 1, 600);
        return $urandom;
    endfunction

    // Choose the next byte so that most frames are well formed
    function automatic logic [7:0] next_byte(logic [31:0] want_len);
        int r;
        logic [31:0] shifted;
        r = $urandom_range(0, 99);
        case (sb.phase)
            ST_HUNT:
            begin
                if (r < 80)
                    return sb.sync_byte;
                if (r < 90)
                    case ($urandom_range(0, 2))
                        0:       return IDLE_BYTE_A;
                        1:       return IDLE_BYTE_B;
                        default: return 8'($urandom_range(128, 255));
                    endcase
                return 8'($urandom);
            end
            ST_ACK:
            begin
                if (r < 80)
                    return sb.ack_byte;
                if (r < 88)
                    return sb.nak_byte;
                return 8'($urandom);
            end
            ST_LEN:
            begin
                shifted = want_len >> (8 * int'(sb.len_cnt));
                return shifted[7:0];
            end
            ST_STATUS:
                return (r < 25) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127));
            ST_CHECK:
                return (r < 85) ? sb.xor_sum : sb.xor_sum ^ 8'($urandom_range(1, 255));
            default:
                return 8'($urandom);
        endcase
    endfunction

    // One exchange: start, then bytes and ticks until the frame ends
    task automatic run_exchange();
        int          steps;
        int          r;
        bit          ticking_out;
        logic [31:0] want_len;
        logic [7:0]  units;
        r = $urandom_range(0, 99);
        units = (r < 50) ? 8'd0 : (r < 80) ? 8'($urandom_range(1, 3)) : 8'($urandom);
        send_item(FUNC_START, 8'($urandom), units);
        want_len = pick_length();
        ticking_out = (int'(sb.tick_limit) - int'(sb.ticks) <= 1500)
                      && ($urandom_range(0, 4) == 0);
        steps = 0;
        while (sb.phase != ST_IDLE && steps < 1500)
        begin
            steps++;
            r = $urandom_range(0, 199);
            if (sb.phase == ST_TYPE)
                want_len = pick_length();
            if (ticking_out || r < 8)
                send_item(FUNC_TICK, 8'($urandom), 8'($urandom));
            else if (r == 8)
                send_item(FUNC_START, 8'($urandom), 8'($urandom_range(0, 3)));
            else if (r == 9)
                send_item(FUNC_SPARE, 8'($urandom), 8'($urandom));
            else
                send_item(FUNC_BYTE, next_byte(want_len), 8'($urandom));
        end
        // Stray items while idle are dropped by the block
        if ($urandom_range(0, 9) == 0)
            send_item(FUNC_BYTE, 8'($urandom), 8'($urandom));
    endtask

    task automatic run_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            steady = ($urandom_range(0, 4) == 0);
            run_exchange();
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
        steady = 1'b0;
    endtask

    // Good frame with one payload byte, nak, oversized length, unused func
    task automatic directed_frames();
        logic [7:0] hdr[$];
        hdr = '{RST_SYNC, RST_ACK, 8'hA5, 8'h01, 8'h00, 8'h00, 8'h00,
                8'hFF, 8'h00, 8'h7F, 8'h80, 8'h3C, 8'hFF};
        send_item(FUNC_START, 8'h00, 8'h00);
        foreach (hdr[i])
            send_item(FUNC_BYTE, hdr[i], 8'hFF);
        send_item(FUNC_BYTE, sb.xor_sum, 8'h00);
        send_item(FUNC_START, 8'hFF, 8'hFF);
        send_item(FUNC_BYTE, IDLE_BYTE_A, 8'h00);
        send_item(FUNC_BYTE, RST_SYNC, 8'h00);
        send_item(FUNC_SPARE, 8'h00, 8'h00);
        send_item(FUNC_BYTE, RST_NAK, 8'h00);
        hdr = '{RST_SYNC, RST_ACK, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_item(FUNC_START, 8'h00, 8'h01);
        foreach (hdr[i])
            send_item(FUNC_BYTE, hdr[i], 8'h00);
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_frames();
        run_phase(280);

        write_all(8'h00, 8'hFF, 8'h80, 14'd1, 14'd1);
        run_phase(280);

        // Ack equal to nak: ack wins
        write_all(8'hFF, IDLE_BYTE_A, IDLE_BYTE_A, 14'd16383, 14'd16383);
        run_phase(280);

        // Sync equal to an idle byte: sync wins
        write_all(IDLE_BYTE_A, 8'h00, 8'hFF, 14'd2, 14'd5);
        run_phase(280);

        write_all(8'($urandom), 8'($urandom), 8'($urandom),
                  14'($urandom_range(1, 16383)), 14'($urandom_range(1, 600)));
        run_phase(280);

        // Wait for the last results, then let the block settle
        s_tvalid = 1'b0;
        @(posedge clk);
        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: reader_response_frame_parser.f
rtl/core/rrfp_pkg.sv
rtl/core/rrfp_cfg.sv
rtl/core/rrfp_in_stage.sv
rtl/core/rrfp_core.sv
rtl/core/reader_response_frame_parser.sv
tb/reader_response_frame_parser_tb.sv
